// ===== src/rsbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsbs_pkg: shared types and constants of the radio scan back-off scheduler
// holds register layout, reset values, action codes and the state and result
// records passed between the top level and the step logic
// ----------------------------------------------------------------------------
package rsbs_pkg;

	localparam int TIME_W    = 32;
	localparam int PERIOD_W  = 27;
	localparam int TIMEOUT_W = 20;
	localparam int DRY_W     = 10;
	localparam int FOUND_W   = 8;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	localparam logic [DRY_W-1:0] DRY_MAX = DRY_W'(1000);

	localparam logic                 RST_AUTO_EN     = 1'b1;
	localparam logic [PERIOD_W-1:0]  RST_CONN_PERIOD = PERIOD_W'(600000);
	localparam logic [PERIOD_W-1:0]  RST_SHORT_PER   = PERIOD_W'(120000);
	localparam logic [PERIOD_W-1:0]  RST_LONG_PER    = PERIOD_W'(300000);
	localparam logic [PERIOD_W-1:0]  RST_RETRY_DLY   = PERIOD_W'(30000);
	localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT     = TIMEOUT_W'(5000);
	localparam logic [DRY_W-1:0]     RST_DRY_THR     = DRY_W'(5);

	typedef enum logic [2:0] {
		ACT_NONE     = 3'd0,
		ACT_EVAL     = 3'd1,
		ACT_RETRY    = 3'd2,
		ACT_DISC     = 3'd3,
		ACT_STARTED  = 3'd4,
		ACT_GAVE_UP  = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		REG_AUTO_EN     = 3'd0,
		REG_CONN_PERIOD = 3'd1,
		REG_SHORT_PER   = 3'd2,
		REG_LONG_PER    = 3'd3,
		REG_RETRY_DLY   = 3'd4,
		REG_TIMEOUT     = 3'd5,
		REG_DRY_THR     = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic                 auto_en;
		logic [PERIOD_W-1:0]  conn_period;
		logic [PERIOD_W-1:0]  short_period;
		logic [PERIOD_W-1:0]  long_period;
		logic [PERIOD_W-1:0]  retry_delay;
		logic [TIMEOUT_W-1:0] start_timeout;
		logic [DRY_W-1:0]     dry_thr;
	} cfg_t;

	typedef struct packed {
		logic             prev_screen;
		logic             scanning;
		logic             pending;
		logic [DRY_W-1:0] dry_count;
	} flags_t;

	typedef struct packed {
		logic               screen_on;
		logic               link_connected;
		logic               user_disabled;
		logic               reconnect_allowed;
		logic               scan_running;
		logic [FOUND_W-1:0] scan_found;
		logic               scan_start_ok;
	} tick_t;

	typedef struct packed {
		action_t            action;
		logic               start_attempt;
		logic [FOUND_W-1:0] networks_found;
		logic               scan_busy;
	} res_t;

endpackage
`default_nettype wire

// ===== src/rsbs_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsbs_step: next-state and action logic for one tick
// polls a running scan, checks whether a scan is due, and handles start
// attempts and the start timeout
// ----------------------------------------------------------------------------
module rsbs_step #(
	parameter int TIME_WIDTH = rsbs_pkg::TIME_W
) (
	input  rsbs_pkg::cfg_t         cfg,
	input  rsbs_pkg::flags_t       st,
	input  logic [TIME_WIDTH-1:0]  last_scan,
	input  logic [TIME_WIDTH-1:0]  pending_since,
	input  logic [TIME_WIDTH-1:0]  now,
	input  rsbs_pkg::tick_t        tick,
	output rsbs_pkg::flags_t       st_nx,
	output logic [TIME_WIDTH-1:0]  last_scan_nx,
	output logic [TIME_WIDTH-1:0]  pending_since_nx,
	output rsbs_pkg::res_t         res
);

	localparam int CMP_W = (TIME_WIDTH > rsbs_pkg::PERIOD_W) ? TIME_WIDTH : rsbs_pkg::PERIOD_W;

	logic                          wake;
	logic                          gate_open;
	logic [rsbs_pkg::PERIOD_W-1:0] period;
	logic [TIME_WIDTH-1:0]         elapsed_last;
	logic [TIME_WIDTH-1:0]         since_eff;
	logic [TIME_WIDTH-1:0]         elapsed_pend;
	logic [TIME_WIDTH-1:0]         retry_time;
	logic                          due;
	logic                          timed_out;
	logic [rsbs_pkg::DRY_W-1:0]    dry_inc;

	assign wake      = tick.screen_on & ~st.prev_screen;
	assign gate_open = ~tick.user_disabled & tick.reconnect_allowed & cfg.auto_en;

	always_comb begin
		if (tick.link_connected) begin
			period = cfg.conn_period;
		end else if (st.dry_count >= cfg.dry_thr) begin
			period = cfg.long_period;
		end else begin
			period = cfg.short_period;
		end
	end

	assign elapsed_last = now - last_scan;
	assign due = (CMP_W'(elapsed_last) >= CMP_W'(period)) | (wake & ~tick.link_connected);

	// a freshly pending scan starts its timeout window at this tick
	assign since_eff    = st.pending ? pending_since : now;
	assign elapsed_pend = now - since_eff;
	assign timed_out    = CMP_W'(elapsed_pend) > CMP_W'(cfg.start_timeout);

	assign retry_time = now - TIME_WIDTH'(cfg.conn_period) + TIME_WIDTH'(cfg.retry_delay);
	assign dry_inc    = (st.dry_count < rsbs_pkg::DRY_MAX) ? st.dry_count + 1'b1 : st.dry_count;

	always_comb begin
		logic go;
		go                   = 1'b0;
		st_nx                = st;
		st_nx.prev_screen    = tick.screen_on;
		last_scan_nx         = last_scan;
		pending_since_nx     = pending_since;
		res.action           = rsbs_pkg::ACT_NONE;
		res.start_attempt    = 1'b0;
		res.networks_found   = '0;
		if (gate_open) begin
			if (st.scanning) begin
				if (!tick.scan_running) begin
					st_nx.scanning = 1'b0;
					if (tick.scan_found != '0) begin
						res.action         = rsbs_pkg::ACT_EVAL;
						res.networks_found = tick.scan_found;
					end else begin
						res.action   = rsbs_pkg::ACT_RETRY;
						last_scan_nx = retry_time;
					end
				end
			end else if (st.pending) begin
				go = 1'b1;
			end else if (due) begin
				last_scan_nx     = now;
				st_nx.dry_count  = tick.link_connected ? '0 : dry_inc;
				st_nx.pending    = 1'b1;
				pending_since_nx = now;
				if (tick.link_connected) begin
					go = 1'b1;
				end else begin
					res.action = rsbs_pkg::ACT_DISC;
				end
			end
			if (go) begin
				res.start_attempt = 1'b1;
				if (tick.scan_start_ok) begin
					st_nx.pending  = 1'b0;
					st_nx.scanning = 1'b1;
					res.action     = rsbs_pkg::ACT_STARTED;
				end else if (timed_out) begin
					st_nx.pending = 1'b0;
					last_scan_nx  = retry_time;
					res.action    = rsbs_pkg::ACT_GAVE_UP;
				end
			end
		end
		res.scan_busy = st_nx.pending | st_nx.scanning;
	end

endmodule
`default_nettype wire

// ===== src/radio_scan_backoff_scheduler_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radio_scan_backoff_scheduler_unit: radio scan back-off scheduler
// takes one tick per transfer and returns one action per tick
// ----------------------------------------------------------------------------
// path: a result is offered once its tick has passed the tick register
// and then the result register
// throughput: one tick per cycle while the action channel is not stalled;
// scheduler state updates as a tick moves from tick into result register
// reset: clears valids and scheduler state, loads register defaults
module radio_scan_backoff_scheduler_unit #(
	parameter int TIME_WIDTH = rsbs_pkg::TIME_W
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// tick channel
	input  wire logic                              tick_valid,
	output      logic                              tick_stall,
	input  wire logic [TIME_WIDTH-1:0]             now_ms,
	input  wire logic                              screen_on,
	input  wire logic                              link_connected,
	input  wire logic                              user_disabled,
	input  wire logic                              reconnect_allowed,
	input  wire logic                              scan_running,
	input  wire logic [rsbs_pkg::FOUND_W-1:0]      scan_found,
	input  wire logic                              scan_start_ok,
	// action channel
	output      logic                              act_valid,
	input  wire logic                              act_stall,
	output      logic [2:0]                        action,
	output      logic                              start_attempt,
	output      logic [rsbs_pkg::FOUND_W-1:0]      networks_found,
	output      logic                              scan_busy,
	// register port
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [rsbs_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [rsbs_pkg::DATA_W-1:0]       pwdata,
	output      logic [rsbs_pkg::DATA_W-1:0]       prdata,
	output      logic                              pready
);

	rsbs_pkg::cfg_t         cfg_q;
	rsbs_pkg::flags_t       st_q;
	rsbs_pkg::flags_t       st_nx;
	logic [TIME_WIDTH-1:0]  last_scan_q;
	logic [TIME_WIDTH-1:0]  last_scan_nx;
	logic [TIME_WIDTH-1:0]  pending_since_q;
	logic [TIME_WIDTH-1:0]  pending_since_nx;

	logic                   valid_s1;
	rsbs_pkg::tick_t        tick_s1;
	logic [TIME_WIDTH-1:0]  now_s1;
	rsbs_pkg::res_t         res_nx;
	rsbs_pkg::res_t         res_q;
	logic                   act_valid_q;

	logic                   advance;
	logic                   wr_en;
	rsbs_pkg::reg_idx_t     reg_idx;

	// register port
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = rsbs_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_en       <= rsbs_pkg::RST_AUTO_EN;
			cfg_q.conn_period   <= rsbs_pkg::RST_CONN_PERIOD;
			cfg_q.short_period  <= rsbs_pkg::RST_SHORT_PER;
			cfg_q.long_period   <= rsbs_pkg::RST_LONG_PER;
			cfg_q.retry_delay   <= rsbs_pkg::RST_RETRY_DLY;
			cfg_q.start_timeout <= rsbs_pkg::RST_TIMEOUT;
			cfg_q.dry_thr       <= rsbs_pkg::RST_DRY_THR;
		end else if (wr_en) begin
			case (reg_idx)
				rsbs_pkg::REG_AUTO_EN:     cfg_q.auto_en       <= pwdata[0];
				rsbs_pkg::REG_CONN_PERIOD: cfg_q.conn_period   <= pwdata[rsbs_pkg::PERIOD_W-1:0];
				rsbs_pkg::REG_SHORT_PER:   cfg_q.short_period  <= pwdata[rsbs_pkg::PERIOD_W-1:0];
				rsbs_pkg::REG_LONG_PER:    cfg_q.long_period   <= pwdata[rsbs_pkg::PERIOD_W-1:0];
				rsbs_pkg::REG_RETRY_DLY:   cfg_q.retry_delay   <= pwdata[rsbs_pkg::PERIOD_W-1:0];
				rsbs_pkg::REG_TIMEOUT:     cfg_q.start_timeout <= pwdata[rsbs_pkg::TIMEOUT_W-1:0];
				rsbs_pkg::REG_DRY_THR:     cfg_q.dry_thr       <= pwdata[rsbs_pkg::DRY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rsbs_pkg::REG_AUTO_EN:     prdata = rsbs_pkg::DATA_W'(cfg_q.auto_en);
			rsbs_pkg::REG_CONN_PERIOD: prdata = rsbs_pkg::DATA_W'(cfg_q.conn_period);
			rsbs_pkg::REG_SHORT_PER:   prdata = rsbs_pkg::DATA_W'(cfg_q.short_period);
			rsbs_pkg::REG_LONG_PER:    prdata = rsbs_pkg::DATA_W'(cfg_q.long_period);
			rsbs_pkg::REG_RETRY_DLY:   prdata = rsbs_pkg::DATA_W'(cfg_q.retry_delay);
			rsbs_pkg::REG_TIMEOUT:     prdata = rsbs_pkg::DATA_W'(cfg_q.start_timeout);
			rsbs_pkg::REG_DRY_THR:     prdata = rsbs_pkg::DATA_W'(cfg_q.dry_thr);
			default:                   prdata = '0;
		endcase
	end

	// handshake: result register frees up when empty or taken
	assign advance    = ~act_valid_q | ~act_stall;
	assign tick_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!tick_stall) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!tick_stall && tick_valid) begin
			now_s1                    <= now_ms;
			tick_s1.screen_on         <= screen_on;
			tick_s1.link_connected    <= link_connected;
			tick_s1.user_disabled     <= user_disabled;
			tick_s1.reconnect_allowed <= reconnect_allowed;
			tick_s1.scan_running      <= scan_running;
			tick_s1.scan_found        <= scan_found;
			tick_s1.scan_start_ok     <= scan_start_ok;
		end
	end

	rsbs_step #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_step (
		.cfg              (cfg_q),
		.st               (st_q),
		.last_scan        (last_scan_q),
		.pending_since    (pending_since_q),
		.now              (now_s1),
		.tick             (tick_s1),
		.st_nx            (st_nx),
		.last_scan_nx     (last_scan_nx),
		.pending_since_nx (pending_since_nx),
		.res              (res_nx)
	);

	// scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q            <= '0;
			last_scan_q     <= '0;
			pending_since_q <= '0;
		end else if (valid_s1 && advance) begin
			st_q            <= st_nx;
			last_scan_q     <= last_scan_nx;
			pending_since_q <= pending_since_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_valid_q <= 1'b0;
		end else if (advance) begin
			act_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_nx;
		end
	end

	assign act_valid      = act_valid_q;
	assign action         = res_q.action;
	assign start_attempt  = res_q.start_attempt;
	assign networks_found = res_q.networks_found;
	assign scan_busy      = res_q.scan_busy;

endmodule
`default_nettype wire

// ===== src/rsbs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsbs_checker: port-level checks of the scheduler
// watches the action channel and the consistency of each reported action
// ----------------------------------------------------------------------------
module rsbs_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         act_valid,
	input wire logic                         act_stall,
	input wire logic [2:0]                   action,
	input wire logic                         start_attempt,
	input wire logic [rsbs_pkg::FOUND_W-1:0] networks_found,
	input wire logic                         scan_busy
);

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		act_valid && act_stall |=> act_valid && $stable(action)
			&& $stable(networks_found))
		else $error("stalled result changed");

	// count is handed over only with an evaluate action
	assert property (@(posedge clk) disable iff (!arst_n)
		act_valid |-> ((action == rsbs_pkg::ACT_EVAL) == (networks_found != '0)))
		else $error("networks_found does not match action");

	// a started scan comes from a start attempt and leaves the scheduler busy
	assert property (@(posedge clk) disable iff (!arst_n)
		act_valid && action == rsbs_pkg::ACT_STARTED |-> start_attempt && scan_busy)
		else $error("started without attempt or busy");

	// retry and give-up leave the scheduler idle
	assert property (@(posedge clk) disable iff (!arst_n)
		act_valid && (action == rsbs_pkg::ACT_RETRY || action == rsbs_pkg::ACT_GAVE_UP)
			|-> !scan_busy && (start_attempt == (action == rsbs_pkg::ACT_GAVE_UP)))
		else $error("retry or give-up left scheduler busy");

	// a disconnect request leaves a scan pending without a start attempt
	assert property (@(posedge clk) disable iff (!arst_n)
		act_valid && action == rsbs_pkg::ACT_DISC |-> scan_busy && !start_attempt)
		else $error("disconnect action inconsistent");

endmodule

bind radio_scan_backoff_scheduler_unit rsbs_checker u_rsbs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.act_valid      (act_valid),
	.act_stall      (act_stall),
	.action         (action),
	.start_attempt  (start_attempt),
	.networks_found (networks_found),
	.scan_busy      (scan_busy)
);
`default_nettype wire
